// ===== src/cartridge_bank_mapper_scanline_irq_assert.svh =====
// Assertion macros shared by the checker of the bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bank mapper check failed");

// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bank mapper check failed");

`endif

// ===== src/cbm_pkg.sv =====
// Types, codes and helpers of the cartridge bank mapper.
package cbm_pkg;

    localparam int BankRegCount = 8;
    localparam int BankIdxW     = $clog2(BankRegCount);
    localparam int PrgRamBytes  = 8192;
    localparam int PrgRamAw     = $clog2(PrgRamBytes);
    localparam int MemAddrW     = 21;
    localparam int CountW       = 9;

    localparam logic [2:0] ACT_CPU_RD   = 3'd0;
    localparam logic [2:0] ACT_CPU_WR   = 3'd1;
    localparam logic [2:0] ACT_PPU_RD   = 3'd2;
    localparam logic [2:0] ACT_PPU_WR   = 3'd3;
    localparam logic [2:0] ACT_SCANLINE = 3'd4;
    localparam logic [2:0] ACT_IRQ_CLR  = 3'd5;

    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_PRG_ROM = 2'd1;
    localparam logic [1:0] TGT_PRG_RAM = 2'd2;
    localparam logic [1:0] TGT_CHR     = 2'd3;

    localparam logic [1:0] CFG_PRG_BANKS = 2'd0;
    localparam logic [1:0] CFG_CHR_BANKS = 2'd1;
    localparam logic [1:0] CFG_CHR_WR    = 2'd2;
    localparam logic [1:0] CFG_MIRROR    = 2'd3;

    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;

    localparam int SEL_PRG_SWAP = 6;
    localparam int SEL_CHR_INV  = 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_FINISH
    } t_state;

    // A bank count of zero behaves as a single bank.
    function automatic logic [CountW-1:0] bank_count(input logic [CountW-1:0] cnt);
        bank_count = (cnt == '0) ? CountW'(1) : cnt;
    endfunction

endpackage

// ===== src/cartridge_bank_mapper_scanline_irq.sv =====
// Bank mapper with scanline IRQ counter: address translation and register file.
//
// Usage: drive action, bus address and write byte and raise start; a request is
// taken at a clock edge where start is high and busy is low. Each request gives
// exactly one result, shown for one cycle with o_done high: target memory,
// translated byte address, write strobe, read-as-zero, handled flag, current
// mirroring and the IRQ line after the request. The receiver cannot stall.
// A request whose bank number needs reduction modulo the configured bank count
// (switchable program banks, handled pattern accesses) runs the shared
// compare-subtract unit in the divide state, one bit per cycle for all eight
// bank-number bits; every other request goes from load to finish. busy drops
// in the cycle the result is shown, so a new request can be taken at the edge
// that ends it. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while idle, which the user must ensure; the block does not enforce it.
// Synchronous reset restores the power-on registers: RAM enabled, mirroring
// from the header setting, IRQ counter cleared and the sequencer idle.
module cartridge_bank_mapper_scanline_irq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_action,
    input  logic [15:0]                  i_bus_addr,
    input  logic [7:0]                   i_write_byte,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [cbm_pkg::CountW-1:0]   i_cfg_data,
    output logic                         o_done,
    output logic [1:0]                   o_target,
    output logic [cbm_pkg::MemAddrW-1:0] o_mem_addr,
    output logic                         o_mem_write,
    output logic                         o_read_zero,
    output logic                         o_handled,
    output logic [1:0]                   o_mirror_mode,
    output logic                         o_irq_line
);
    import cbm_pkg::*;

    t_state r_state, n_state;

    logic [2:0]  r_action;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    logic [CountW-1:0] r_prg_cnt, r_chr_cnt;
    logic              r_chr_wr;
    logic [1:0]        r_hdr_mirror;

    logic [7:0] r_select, n_select;
    logic [7:0] r_bank_regs [BankRegCount];
    logic       r_ram_en, n_ram_en;
    logic       r_ram_prot, n_ram_prot;
    logic       r_mir_written, n_mir_written;
    logic       r_mir_horiz, n_mir_horiz;
    logic [7:0] r_irq_reload, n_irq_reload;
    logic [7:0] r_line_cnt, n_line_cnt;
    logic       r_reload_req, n_reload_req;
    logic       r_irq_en, n_irq_en;
    logic       r_irq_pend, n_irq_pend;

    logic                bk_we;
    logic [BankIdxW-1:0] bk_widx;

    // Shared compare-subtract unit state.
    logic [CountW-1:0] r_rem, n_rem;
    logic [7:0]        r_dvd, n_dvd;
    logic [CountW-1:0] r_dvs, n_dvs;
    logic [2:0]        r_cnt;
    logic              r_need_mod, n_need_mod;

    logic [CountW-1:0]   prg_banks, chr_banks, last2;
    logic                cpu_rom, chr_acc, swap;
    logic [1:0]          slot;
    logic [2:0]          region;
    logic [BankIdxW-1:0] rd_idx;
    logic [7:0]          rd_bank, chr_dvd;
    logic [CountW:0]     trial;
    logic                div_ge;

    logic [1:0]          f_target;
    logic [MemAddrW-1:0] f_addr;
    logic                f_write, f_zero, f_handled;

    assign busy = (r_state != S_IDLE);

    assign prg_banks = bank_count(r_prg_cnt);
    assign chr_banks = bank_count(r_chr_cnt);
    assign last2     = (prg_banks >= CountW'(2)) ? prg_banks - CountW'(2) : '0;
    assign cpu_rom   = (r_action == ACT_CPU_RD) && r_addr[15];
    assign chr_acc   = (r_addr[15:13] == 3'b000) &&
                       ((r_action == ACT_PPU_RD) || ((r_action == ACT_PPU_WR) && r_chr_wr));
    assign swap      = r_select[SEL_PRG_SWAP];
    assign slot      = r_addr[14:13];
    assign region    = r_addr[12:10] ^ {r_select[SEL_CHR_INV], 2'b00};

    // One bank register is read per request; upper pattern regions map to 2..5.
    always_comb begin
        if (cpu_rom) begin
            rd_idx = (slot == 2'd1) ? BankIdxW'(7) : BankIdxW'(6);
        end else if (region[2]) begin
            rd_idx = BankIdxW'(region - 3'd2);
        end else begin
            rd_idx = BankIdxW'(region[1]);
        end
    end

    assign rd_bank = r_bank_regs[rd_idx];
    assign chr_dvd = region[2] ? rd_bank : {rd_bank[7:1], region[0]};

    assign trial  = {r_rem, r_dvd[7]};
    assign div_ge = (trial >= {1'b0, r_dvs});

    // Sequencer and datapath next values.
    always_comb begin
        n_state    = r_state;
        n_rem      = r_rem;
        n_dvd      = r_dvd;
        n_dvs      = r_dvs;
        n_need_mod = r_need_mod;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_dvd = rd_bank;
                n_rem = '0;
                if (cpu_rom) begin
                    n_dvs = prg_banks;
                    case (slot)
                        2'd0: begin
                            n_need_mod = !swap;
                            n_rem      = swap ? last2 : '0;
                        end
                        2'd1: begin
                            n_need_mod = 1'b1;
                        end
                        2'd2: begin
                            n_need_mod = swap;
                            n_rem      = swap ? '0 : last2;
                        end
                        default: begin
                            n_need_mod = 1'b0;
                            n_rem      = prg_banks - CountW'(1);
                        end
                    endcase
                end else begin
                    n_dvs      = chr_banks;
                    n_dvd      = chr_dvd;
                    n_need_mod = chr_acc;
                end
                n_state = n_need_mod ? S_DIV : S_FINISH;
            end
            S_DIV: begin
                // The remainder stays below the divisor, so it fits the count width.
                n_rem = div_ge ? CountW'(trial - {1'b0, r_dvs}) : CountW'(trial);
                n_dvd = {r_dvd[6:0], 1'b0};
                if (r_cnt == 3'd7) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields and register-file updates of the finishing request.
    always_comb begin
        f_target      = TGT_NONE;
        f_addr        = '0;
        f_write       = 1'b0;
        f_zero        = 1'b0;
        f_handled     = 1'b0;
        n_select      = r_select;
        n_ram_en      = r_ram_en;
        n_ram_prot    = r_ram_prot;
        n_mir_written = r_mir_written;
        n_mir_horiz   = r_mir_horiz;
        n_irq_reload  = r_irq_reload;
        n_line_cnt    = r_line_cnt;
        n_reload_req  = r_reload_req;
        n_irq_en      = r_irq_en;
        n_irq_pend    = r_irq_pend;
        bk_we         = 1'b0;
        bk_widx       = BankIdxW'(r_select);
        case (r_action)
            ACT_CPU_RD: begin
                if (r_addr[15]) begin
                    f_handled = 1'b1;
                    f_target  = TGT_PRG_ROM;
                    f_addr    = {r_rem[7:0], r_addr[12:0]};
                end else if (r_addr[14:13] == 2'b11) begin
                    f_handled = 1'b1;
                    f_target  = TGT_PRG_RAM;
                    f_addr    = MemAddrW'(r_addr[PrgRamAw-1:0]);
                    f_zero    = !r_ram_en;
                end
            end
            ACT_CPU_WR: begin
                if (r_addr[15]) begin
                    f_handled = 1'b1;
                    case (r_addr[14:13])
                        2'd0: begin
                            if (!r_addr[0]) begin
                                n_select = r_data;
                            end else begin
                                bk_we = 1'b1;
                            end
                        end
                        2'd1: begin
                            if (!r_addr[0]) begin
                                n_mir_written = 1'b1;
                                n_mir_horiz   = r_data[0];
                            end else begin
                                n_ram_prot = r_data[6];
                                n_ram_en   = r_data[7];
                            end
                        end
                        2'd2: begin
                            if (!r_addr[0]) begin
                                n_irq_reload = r_data;
                            end else begin
                                n_reload_req = 1'b1;
                            end
                        end
                        default: begin
                            if (!r_addr[0]) begin
                                n_irq_en   = 1'b0;
                                n_irq_pend = 1'b0;
                            end else begin
                                n_irq_en = 1'b1;
                            end
                        end
                    endcase
                end else if (r_addr[14:13] == 2'b11) begin
                    f_handled = 1'b1;
                    f_target  = TGT_PRG_RAM;
                    f_addr    = MemAddrW'(r_addr[PrgRamAw-1:0]);
                    f_write   = r_ram_en && !r_ram_prot;
                end
            end
            ACT_PPU_RD, ACT_PPU_WR: begin
                if (chr_acc) begin
                    f_handled = 1'b1;
                    f_target  = TGT_CHR;
                    f_addr    = MemAddrW'({r_rem[7:0], r_addr[9:0]});
                    f_write   = (r_action == ACT_PPU_WR);
                end
            end
            ACT_SCANLINE: begin
                if ((r_line_cnt == 8'd0) || r_reload_req) begin
                    n_line_cnt   = r_irq_reload;
                    n_reload_req = 1'b0;
                end else begin
                    n_line_cnt = r_line_cnt - 8'd1;
                end
                if ((n_line_cnt == 8'd0) && r_irq_en) begin
                    n_irq_pend = 1'b1;
                end
            end
            ACT_IRQ_CLR: begin
                n_irq_pend = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_action <= i_action;
            r_addr   <= i_bus_addr;
            r_data   <= i_write_byte;
        end
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_need_mod <= n_need_mod;
        r_cnt      <= (r_state == S_DIV) ? r_cnt + 3'd1 : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_cnt    <= CountW'(4);
            r_chr_cnt    <= CountW'(8);
            r_chr_wr     <= 1'b0;
            r_hdr_mirror <= MIR_VERTICAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRG_BANKS: r_prg_cnt    <= i_cfg_data;
                CFG_CHR_BANKS: r_chr_cnt    <= i_cfg_data;
                CFG_CHR_WR:    r_chr_wr     <= i_cfg_data[0];
                CFG_MIRROR:    r_hdr_mirror <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select      <= '0;
            r_ram_en      <= 1'b1;
            r_ram_prot    <= 1'b0;
            r_mir_written <= 1'b0;
            r_mir_horiz   <= 1'b0;
            r_irq_reload  <= '0;
            r_line_cnt    <= '0;
            r_reload_req  <= 1'b0;
            r_irq_en      <= 1'b0;
            r_irq_pend    <= 1'b0;
            for (int i = 0; i < BankRegCount; i++) begin
                r_bank_regs[i] <= '0;
            end
        end else if (r_state == S_FINISH) begin
            r_select      <= n_select;
            r_ram_en      <= n_ram_en;
            r_ram_prot    <= n_ram_prot;
            r_mir_written <= n_mir_written;
            r_mir_horiz   <= n_mir_horiz;
            r_irq_reload  <= n_irq_reload;
            r_line_cnt    <= n_line_cnt;
            r_reload_req  <= n_reload_req;
            r_irq_en      <= n_irq_en;
            r_irq_pend    <= n_irq_pend;
            if (bk_we) begin
                r_bank_regs[bk_widx] <= r_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == S_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH) begin
            o_target      <= f_target;
            o_mem_addr    <= f_addr;
            o_mem_write   <= f_write;
            o_read_zero   <= f_zero;
            o_handled     <= f_handled;
            o_mirror_mode <= n_mir_written ? (n_mir_horiz ? MIR_HORIZONTAL : MIR_VERTICAL)
                                           : r_hdr_mirror;
            o_irq_line    <= n_irq_pend;
        end
    end

endmodule

// ===== src/cbm_checker.sv =====
// Port-level checker of the bank mapper and its bind to the top level.
`include "cartridge_bank_mapper_scanline_irq_assert.svh"

module cbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_target,
    input logic       o_read_zero,
    input logic       o_handled
);
    import cbm_pkg::*;

    // A taken request keeps the block busy until its result is shown.
    `CBM_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `CBM_ASSERT_NOW(a_idle_at_done, i_clk, i_rst_n, o_done, !busy)
    `CBM_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done)
    `CBM_ASSERT_NOW(a_zero_is_ram, i_clk, i_rst_n, o_done && o_read_zero, (o_target == TGT_PRG_RAM) && o_handled)

endmodule

bind cartridge_bank_mapper_scanline_irq cbm_checker u_cbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_target    (o_target),
    .o_read_zero (o_read_zero),
    .o_handled   (o_handled)
);

// ===== bench/cartridge_bank_mapper_scanline_irq_checker.sv =====
// Checker for the bank mapper: tracks mapper state, predicts each result and compares it.
module cartridge_bank_mapper_scanline_irq_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [2:0]                   i_action,
    input  logic [15:0]                  i_bus_addr,
    input  logic [7:0]                   i_write_byte,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [cbm_pkg::CountW-1:0]   i_cfg_data,
    input  logic                         i_done,
    input  logic [1:0]                   i_target,
    input  logic [cbm_pkg::MemAddrW-1:0] i_mem_addr,
    input  logic                         i_mem_write,
    input  logic                         i_read_zero,
    input  logic                         i_handled,
    input  logic [1:0]                   i_mirror_mode,
    input  logic                         i_irq_line,
    output logic [15:0]                  o_pending,
    output int                           o_failures
);
    import cbm_pkg::*;

    typedef struct packed {
        logic [1:0]          target;
        logic [MemAddrW-1:0] mem_addr;
        logic                mem_write;
        logic                read_zero;
        logic                handled;
        logic [1:0]          mirror;
        logic                irq;
    } mapper_result_t;

    // Configuration copy.
    logic [CountW-1:0] prg_banks;
    logic [CountW-1:0] chr_banks;
    logic              chr_ram;
    logic [1:0]        header_mirror;

    // Mapper state copy.
    logic [7:0] bank_select;
    logic [7:0] bank_reg [BankRegCount];
    logic       ram_en;
    logic       ram_wp;
    logic       mirror_set;
    logic       mirror_horiz;
    logic [7:0] irq_latch;
    logic [7:0] line_counter;
    logic       reload_pending;
    logic       irq_armed;
    logic       irq_flag;

    mapper_result_t translations_due [$];
    int             failures = 0;

    assign o_failures = failures;

    function automatic logic [MemAddrW-1:0] chr_translate(input logic [15:0] addr);
        int unsigned banks;
        int unsigned bank;
        logic [2:0]  region;
        banks  = (chr_banks == '0) ? 1 : chr_banks;
        region = addr[12:10];
        if (bank_select[SEL_CHR_INV]) region ^= 3'd4;
        case (region)
            3'd0: bank = {bank_reg[0][7:1], 1'b0};
            3'd1: bank = {bank_reg[0][7:1], 1'b0} + 1;
            3'd2: bank = {bank_reg[1][7:1], 1'b0};
            3'd3: bank = {bank_reg[1][7:1], 1'b0} + 1;
            default: bank = bank_reg[region - 3'd2];
        endcase
        return MemAddrW'((bank % banks) * 32'h400 + addr[9:0]);
    endfunction

    // Applies one request to the state copy and returns the result it should produce.
    task automatic translate_access(input logic [2:0] act, input logic [15:0] addr,
                                    input logic [7:0] data, output mapper_result_t res);
        int unsigned banks;
        int unsigned last2;
        int unsigned bank;
        res = '0;
        case (act)
            ACT_CPU_RD: begin
                if (addr >= 16'h8000) begin
                    banks = (prg_banks == '0) ? 1 : prg_banks;
                    last2 = (banks >= 2) ? banks - 2 : 0;
                    case (addr[14:13])
                        2'd0: bank = bank_select[SEL_PRG_SWAP] ? last2 : bank_reg[6] % banks;
                        2'd1: bank = bank_reg[7] % banks;
                        2'd2: bank = bank_select[SEL_PRG_SWAP] ? bank_reg[6] % banks : last2;
                        default: bank = banks - 1;
                    endcase
                    res.handled  = 1'b1;
                    res.target   = TGT_PRG_ROM;
                    res.mem_addr = MemAddrW'(bank * 32'h2000 + addr[12:0]);
                end else if (addr >= 16'h6000) begin
                    res.handled   = 1'b1;
                    res.target    = TGT_PRG_RAM;
                    res.mem_addr  = MemAddrW'(addr[PrgRamAw-1:0]);
                    res.read_zero = !ram_en;
                end
            end
            ACT_CPU_WR: begin
                if (addr >= 16'h8000) begin
                    res.handled = 1'b1;
                    case (addr[14:13])
                        2'd0: begin
                            if (!addr[0]) bank_select = data;
                            else bank_reg[bank_select[BankIdxW-1:0]] = data;
                        end
                        2'd1: begin
                            if (!addr[0]) begin
                                mirror_set   = 1'b1;
                                mirror_horiz = data[0];
                            end else begin
                                ram_wp = data[6];
                                ram_en = data[7];
                            end
                        end
                        2'd2: begin
                            if (!addr[0]) irq_latch = data;
                            else reload_pending = 1'b1;
                        end
                        default: begin
                            // The even address also acknowledges a pending interrupt.
                            if (!addr[0]) begin
                                irq_armed = 1'b0;
                                irq_flag  = 1'b0;
                            end else begin
                                irq_armed = 1'b1;
                            end
                        end
                    endcase
                end else if (addr >= 16'h6000) begin
                    res.handled   = 1'b1;
                    res.target    = TGT_PRG_RAM;
                    res.mem_addr  = MemAddrW'(addr[PrgRamAw-1:0]);
                    res.mem_write = ram_en && !ram_wp;
                end
            end
            ACT_PPU_RD: begin
                if (addr < 16'h2000) begin
                    res.handled  = 1'b1;
                    res.target   = TGT_CHR;
                    res.mem_addr = chr_translate(addr);
                end
            end
            ACT_PPU_WR: begin
                if (addr < 16'h2000 && chr_ram) begin
                    res.handled   = 1'b1;
                    res.target    = TGT_CHR;
                    res.mem_addr  = chr_translate(addr);
                    res.mem_write = 1'b1;
                end
            end
            ACT_SCANLINE: begin
                if (line_counter == 8'd0 || reload_pending) begin
                    line_counter   = irq_latch;
                    reload_pending = 1'b0;
                end else begin
                    line_counter = line_counter - 8'd1;
                end
                if (line_counter == 8'd0 && irq_armed) irq_flag = 1'b1;
            end
            ACT_IRQ_CLR: irq_flag = 1'b0;
            default: ;
        endcase
        res.mirror = mirror_set ? (mirror_horiz ? MIR_HORIZONTAL : MIR_VERTICAL) : header_mirror;
        res.irq    = irq_flag;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        mapper_result_t want;
        mapper_result_t next_res;
        if (!i_rst_n) begin
            prg_banks      = 9'd4;
            chr_banks      = 9'd8;
            chr_ram        = 1'b0;
            header_mirror  = MIR_VERTICAL;
            bank_select    = '0;
            for (int i = 0; i < BankRegCount; i++) bank_reg[i] = '0;
            ram_en         = 1'b1;
            ram_wp         = 1'b0;
            mirror_set     = 1'b0;
            mirror_horiz   = 1'b0;
            irq_latch      = '0;
            line_counter   = '0;
            reload_pending = 1'b0;
            irq_armed      = 1'b0;
            irq_flag       = 1'b0;
            translations_due.delete();
            o_pending <= '0;
        end else begin
            // The result leaving this cycle belongs to an older request than any taken now.
            if (i_done) begin
                if (translations_due.size() == 0) begin
                    failures++;
                    $display("%0t: result with no request outstanding, expected none, got 0x%0h",
                             $time, {i_target, i_mem_addr, i_mem_write, i_read_zero, i_handled,
                                     i_mirror_mode, i_irq_line});
                end else begin
                    want = translations_due.pop_front();
                    compare_field("target", want.target, i_target);
                    compare_field("mem_addr", want.mem_addr, i_mem_addr);
                    compare_field("mem_write", want.mem_write, i_mem_write);
                    compare_field("read_zero", want.read_zero, i_read_zero);
                    compare_field("handled", want.handled, i_handled);
                    compare_field("mirror_mode", want.mirror, i_mirror_mode);
                    compare_field("irq_line", want.irq, i_irq_line);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRG_BANKS: prg_banks     = i_cfg_data;
                    CFG_CHR_BANKS: chr_banks     = i_cfg_data;
                    CFG_CHR_WR:    chr_ram       = i_cfg_data[0];
                    CFG_MIRROR:    header_mirror = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                translate_access(i_action, i_bus_addr, i_write_byte, next_res);
                translations_due.push_back(next_res);
            end
            o_pending <= 16'(translations_due.size());
        end
    end

endmodule

// ===== bench/tb_cartridge_bank_mapper_scanline_irq.sv =====
// Testbench top for the bank mapper: request stimulus, register settings and verdict.
module tb_cartridge_bank_mapper_scanline_irq;
    import cbm_pkg::*;

    localparam logic [2:0]  ACT_RESERVED_6  = 3'd6;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_RAM_PROTECT = 16'hA001;
    localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;
    localparam int          STALL_LIMIT     = 1000;
    localparam int          PHASE_REQUESTS  = 45;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic [2:0]          i_action     = '0;
    logic [15:0]         i_bus_addr   = '0;
    logic [7:0]          i_write_byte = '0;
    logic                i_cfg_we     = 1'b0;
    logic [1:0]          i_cfg_idx    = '0;
    logic [CountW-1:0]   i_cfg_data   = '0;
    logic                busy;
    logic                o_done;
    logic [1:0]          o_target;
    logic [MemAddrW-1:0] o_mem_addr;
    logic                o_mem_write;
    logic                o_read_zero;
    logic                o_handled;
    logic [1:0]          o_mirror_mode;
    logic                o_irq_line;
    logic [15:0]         results_due;
    int                  failures;
    int                  stall_cycles     = 0;
    int                  requests_sent    = 0;
    int                  settings_applied = 0;

    always #5 i_clk = ~i_clk;

    cartridge_bank_mapper_scanline_irq uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_bus_addr    (i_bus_addr),
        .i_write_byte  (i_write_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_target      (o_target),
        .o_mem_addr    (o_mem_addr),
        .o_mem_write   (o_mem_write),
        .o_read_zero   (o_read_zero),
        .o_handled     (o_handled),
        .o_mirror_mode (o_mirror_mode),
        .o_irq_line    (o_irq_line)
    );

    cartridge_bank_mapper_scanline_irq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_bus_addr    (i_bus_addr),
        .i_write_byte  (i_write_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_done        (o_done),
        .i_target      (o_target),
        .i_mem_addr    (o_mem_addr),
        .i_mem_write   (o_mem_write),
        .i_read_zero   (o_read_zero),
        .i_handled     (o_handled),
        .i_mirror_mode (o_mirror_mode),
        .i_irq_line    (o_irq_line),
        .o_pending     (results_due),
        .o_failures    (failures)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Holds start high until the request is taken; start stays high for a back-to-back request.
    task automatic issue_request(input logic [2:0] act, input logic [15:0] addr,
                                 input logic [7:0] data);
        i_action     <= act;
        i_bus_addr   <= addr;
        i_write_byte <= data;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (act <= ACT_IRQ_CLR) requests_sent++;
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 99) < 16) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CountW-1:0] prg, input logic [CountW-1:0] chr,
                                  input logic chr_wr, input logic [1:0] mirror);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PRG_BANKS;
        i_cfg_data <= prg;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CHR_BANKS;
        i_cfg_data <= chr;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CHR_WR;
        i_cfg_data <= CountW'(chr_wr);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIRROR;
        i_cfg_data <= CountW'(mirror);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Mostly meaningful bus traffic, with some raw noise including the undefined actions.
    // Mirroring writes are held back while the header setting is under test.
    task automatic pick_request(input bit mirror_ok, output logic [2:0] act,
                                output logic [15:0] addr, output logic [7:0] data);
        int         r;
        logic [1:0] region;
        logic       odd;
        r    = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (r < 18) begin
            act  = ACT_CPU_RD;
            addr = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
        end else if (r < 26) begin
            act  = $urandom_range(0, 1) ? ACT_CPU_WR : ACT_CPU_RD;
            addr = 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
        end else if (r < 46) begin
            region = 2'($urandom_range(0, 3));
            odd    = 1'($urandom_range(0, 1));
            act    = ACT_CPU_WR;
            addr   = {1'b1, region, 12'($urandom_range(0, 4095)), odd};
            // Short reload values make the scanline interrupt fire often.
            if (region == 2'd2 && !odd && $urandom_range(0, 3) != 0)
                data = 8'($urandom_range(0, 6));
        end else if (r < 66) begin
            act  = ACT_PPU_RD;
            addr = 16'($urandom_range(0, 16'h1FFF));
        end else if (r < 74) begin
            act  = ACT_PPU_WR;
            addr = 16'($urandom_range(0, 16'h1FFF));
        end else if (r < 86) begin
            act  = ACT_SCANLINE;
            addr = 16'($urandom_range(0, 65535));
        end else if (r < 90) begin
            act  = ACT_IRQ_CLR;
            addr = 16'($urandom_range(0, 65535));
        end else begin
            act  = 3'($urandom_range(0, 7));
            addr = 16'($urandom_range(0, 65535));
        end
        if (!mirror_ok && act == ACT_CPU_WR && addr[15:13] == 3'b101) addr[0] = 1'b1;
    endtask

    initial begin
        logic [2:0]  act;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          pauses_on;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the power-on register settings.
        issue_request(ACT_CPU_RD, 16'h0000, 8'h00);
        issue_request(ACT_CPU_RD, 16'hFFFF, 8'h00);
        issue_request(ACT_CPU_RD, 16'h6000, 8'h00);
        issue_request(ACT_CPU_WR, 16'h7FFF, 8'hFF);
        issue_request(ACT_CPU_WR, REG_BANK_SELECT, 8'hC6);
        issue_request(ACT_CPU_WR, REG_BANK_DATA, 8'hFF);
        issue_request(ACT_CPU_RD, 16'h8000, 8'h00);
        issue_request(ACT_CPU_RD, 16'hC000, 8'h00);
        issue_request(ACT_CPU_RD, 16'hA000, 8'h00);
        issue_request(ACT_CPU_WR, REG_RAM_PROTECT, 8'h40);
        issue_request(ACT_CPU_RD, 16'h6123, 8'h00);
        issue_request(ACT_CPU_WR, 16'h6000, 8'h5A);
        issue_request(ACT_CPU_WR, REG_RAM_PROTECT, 8'hC0);
        issue_request(ACT_CPU_WR, 16'h6001, 8'hA5);
        issue_request(ACT_PPU_RD, 16'h0000, 8'h00);
        issue_request(ACT_PPU_RD, 16'h1FFF, 8'h00);
        issue_request(ACT_PPU_WR, 16'h1000, 8'h33);
        issue_request(ACT_PPU_RD, 16'h2000, 8'h00);
        issue_request(ACT_CPU_WR, REG_IRQ_LATCH, 8'h01);
        issue_request(ACT_CPU_WR, REG_IRQ_RELOAD, 8'h00);
        issue_request(ACT_CPU_WR, REG_IRQ_ENABLE, 8'h00);
        issue_request(ACT_SCANLINE, 16'h0000, 8'h00);
        issue_request(ACT_SCANLINE, 16'h0000, 8'h00);
        issue_request(ACT_IRQ_CLR, 16'h0000, 8'h00);
        issue_request(ACT_RESERVED_6, 16'hFFFF, 8'hFF);
        wait_results_drained();

        // Each header mirroring setting, before any mirroring register write overrides it.
        for (int m = 0; m < 4; m++) begin
            apply_settings(CountW'($urandom_range(0, 256)), CountW'($urandom_range(0, 256)),
                           1'($urandom_range(0, 1)), 2'(m));
            repeat (12) begin
                pick_request(1'b0, act, addr, data);
                issue_request(act, addr, data);
                maybe_pause();
            end
            wait_results_drained();
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_settings(9'd0, 9'd0, 1'b1, 2'($urandom_range(0, 3)));
                1: apply_settings(9'd1, 9'd1, 1'b0, 2'($urandom_range(0, 3)));
                2: apply_settings(9'd256, 9'd256, 1'b1, 2'($urandom_range(0, 3)));
                3: apply_settings(9'd255, 9'd255, 1'b0, 2'($urandom_range(0, 3)));
                4: apply_settings(9'd2, 9'd2, 1'b1, 2'($urandom_range(0, 3)));
                default: apply_settings(CountW'($urandom_range(0, 256)),
                                        CountW'($urandom_range(0, 256)),
                                        1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            endcase
            // One phase runs requests back to back with no pauses at all.
            pauses_on = (phase != 2);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                pick_request(1'b1, act, addr, data);
                issue_request(act, addr, data);
                if (pauses_on) maybe_pause();
            end
            wait_results_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d bus and interrupt requests under %0d register settings,",
                 requests_sent, settings_applied);
        $display("including empty, single and 256-bank counts and all header mirroring modes.");
        if (failures == 0 && results_due == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
